@@ sv/gfr_pkg.sv @@
// Shared types and constants for the fraction reducer.
`default_nettype none
package gfr_pkg;
	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture operands
		logic div_start; // start a division
		logic [1:0] div_sel; // what to divide
		logic euclid_upd; // a <= b, b <= rem
		logic q_num_upd;  // store num quotient
		logic q_den_upd;  // store den quotient
		logic out_load;   // load output register
	} gfr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
		logic b_zero;
		logic a_zero;
	} gfr_sts_t;

	localparam logic [1:0] SEL_EUCLID = 2'd0;
	localparam logic [1:0] SEL_NUM = 2'd1;
	localparam logic [1:0] SEL_DEN = 2'd2;
endpackage
`default_nettype wire

@@ sv/gfr_divider.sv @@
// Iterative signed truncating divider, one quotient bit per cycle.
`default_nettype none
module gfr_divider #(
	parameter int DataWidth = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [DataWidth-1:0] dividend,
	input  wire logic [DataWidth-1:0] divisor,
	output logic                      done,
	output logic [DataWidth-1:0]      quotient,
	output logic [DataWidth-1:0]      remainder
);
	localparam int CntW = $clog2(DataWidth + 1);

	logic [DataWidth-1:0] rem_q, quo_q, dvs_q;
	logic [CntW-1:0] cnt_q;
	logic busy_q, qneg_q, rneg_q;
	logic [DataWidth:0] trial;
	logic [DataWidth:0] shifted;

	assign shifted = {rem_q, quo_q[DataWidth-1]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(DataWidth);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[DataWidth-1] ? -dividend : dividend;
			dvs_q <= divisor[DataWidth-1] ? -divisor : divisor;
			qneg_q <= dividend[DataWidth-1] ^ divisor[DataWidth-1];
			rneg_q <= dividend[DataWidth-1];
		end else if (busy_q) begin
			if (!trial[DataWidth]) begin
				rem_q <= trial[DataWidth-1:0];
				quo_q <= {quo_q[DataWidth-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DataWidth-1:0];
				quo_q <= {quo_q[DataWidth-2:0], 1'b0};
			end
		end
	end

	assign quotient = qneg_q ? -quo_q : quo_q;
	assign remainder = rneg_q ? -rem_q : rem_q;
endmodule
`default_nettype wire

@@ sv/gfr_datapath.sv @@
// Operand registers, shared divider and result register.
`default_nettype none
module gfr_datapath #(
	parameter int DataWidth = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire gfr_pkg::gfr_cmd_t     cmd,
	output gfr_pkg::gfr_sts_t          sts,
	input  wire logic [DataWidth-1:0]  in_num,
	input  wire logic [DataWidth-1:0]  in_den,
	output logic [3*DataWidth:0]       result
);
	import gfr_pkg::*;

	logic [DataWidth-1:0] num_q, den_q, a_q, b_q, qn_q, qd_q;
	logic [DataWidth-1:0] dvd, quo, rem;
	logic done;

	always_comb begin
		case (cmd.div_sel)
			SEL_NUM: dvd = num_q;
			SEL_DEN: dvd = den_q;
			default: dvd = a_q;
		endcase
	end

	gfr_divider #(.DataWidth(DataWidth)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .dividend(dvd),
		.divisor(cmd.div_sel == SEL_EUCLID ? b_q : a_q), .done(done),
		.quotient(quo), .remainder(rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q <= in_num;
			den_q <= in_den;
			a_q <= in_num;
			b_q <= in_den;
		end else if (cmd.euclid_upd) begin
			a_q <= b_q;
			b_q <= rem;
		end
		if (cmd.q_num_upd) qn_q <= quo;
		if (cmd.q_den_upd) qd_q <= quo;
		if (cmd.out_load) begin
			if (a_q == '0) result <= {1'b1, {(3*DataWidth){1'b0}}};
			else result <= {1'b0, a_q, qd_q, qn_q};
		end
	end

	assign sts.div_done = done;
	assign sts.b_zero = (b_q == '0);
	assign sts.a_zero = (a_q == '0);
endmodule
`default_nettype wire

@@ sv/gfr_ctrl.sv @@
// Sequencer for the Euclid loop and the two final divisions.
`default_nettype none
module gfr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_fire,
	input  wire logic              out_busy,
	input  wire logic              out_take,
	input  wire gfr_pkg::gfr_sts_t sts,
	output gfr_pkg::gfr_cmd_t      cmd,
	output logic                   idle,
	output logic                   out_set
);
	import gfr_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_TEST = 7'b0000010,
		ST_EDIV = 7'b0000100,
		ST_NDIV = 7'b0001000,
		ST_DDIV = 7'b0010000,
		ST_OUT  = 7'b0100000,
		ST_WAIT = 7'b1000000
	} state_t;

	state_t state_q;

	assign idle = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		out_set = 1'b0;
		cmd.load = (state_q == ST_IDLE) && in_fire;
		unique case (state_q)
			ST_TEST: begin
				if (!sts.b_zero) begin
					cmd.div_start = 1'b1;
					cmd.div_sel = SEL_EUCLID;
				end else if (!sts.a_zero) begin
					cmd.div_start = 1'b1;
					cmd.div_sel = SEL_NUM;
				end
			end
			ST_EDIV: begin
				cmd.div_sel = SEL_EUCLID;
				cmd.euclid_upd = sts.div_done;
			end
			ST_NDIV: begin
				cmd.div_sel = SEL_NUM;
				cmd.q_num_upd = sts.div_done;
				if (sts.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel = SEL_DEN;
				end
			end
			ST_DDIV: begin
				cmd.div_sel = SEL_DEN;
				cmd.q_den_upd = sts.div_done;
			end
			ST_OUT: begin
				if (!out_busy || out_take) begin
					cmd.out_load = 1'b1;
					out_set = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_fire) state_q <= ST_TEST;
				ST_TEST: begin
					if (!sts.b_zero) state_q <= ST_EDIV;
					else if (!sts.a_zero) state_q <= ST_NDIV;
					else state_q <= ST_OUT;
				end
				ST_EDIV: if (sts.div_done) state_q <= ST_TEST;
				ST_NDIV: if (sts.div_done) state_q <= ST_DDIV;
				ST_DDIV: if (sts.div_done) state_q <= ST_OUT;
				ST_OUT: if (!out_busy || out_take) state_q <= ST_IDLE;
				ST_WAIT: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ sv/gcd_fraction_reduce_top.sv @@
// Top level of the signed fraction reducer.
// Channel | Dir | tdata                                   | tuser
// s_axis  | in  | numerator, denominator                   | -
// m_axis  | out | reduced_numerator, reduced_denominator, divisor | zero_error
// Each Euclid step is one remainder on the shared divider.
// One item is worked at a time; the next is accepted once the result is in the
// output register, so a waiting result only stalls a finished item.
// Reset is asynchronous and clears all control state.
`default_nettype none
module gcd_fraction_reduce_top #(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_axis_tvalid,
	output logic                          s_axis_tready,
	// numerator, denominator
	input  wire logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  wire logic                     m_axis_tready,
	// reduced_numerator, reduced_denominator, divisor
	output logic [((3*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// zero_error
	output logic                          m_axis_tuser
);
	import gfr_pkg::*;
	localparam int OutW = ((3*DATA_WIDTH+7)/8)*8;

	gfr_cmd_t cmd;
	gfr_sts_t sts;
	logic idle, out_set, in_fire, out_take;
	logic [3*DATA_WIDTH:0] result;

	assign s_axis_tready = idle;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_take = m_axis_tvalid && m_axis_tready;

	gfr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_busy(m_axis_tvalid),
		.out_take(out_take), .sts(sts), .cmd(cmd), .idle(idle), .out_set(out_set)
	);

	gfr_datapath #(.DataWidth(DATA_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_num(s_axis_tdata[DATA_WIDTH-1:0]),
		.in_den(s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]), .result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (out_set) m_axis_tvalid <= 1'b1;
		else if (out_take) m_axis_tvalid <= 1'b0;
	end

	assign m_axis_tdata = OutW'(result[3*DATA_WIDTH-1:0]);
	assign m_axis_tuser = result[3*DATA_WIDTH];
endmodule
`default_nettype wire

@@ sv/gfr_checker.sv @@
// Port-level checks for the fraction reducer, bound to the top level.
`default_nettype none
module gfr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic m_axis_tuser
);
	// A result held for the sink keeps its flag.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tuser))
		else $error("tuser changed while stalled");
	// After a transfer in, the block is busy on the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("accepted back to back");
	// No result can appear right after an input transfer.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("result too early");
endmodule

bind gcd_fraction_reduce_top gfr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire

@@ tb/gcd_fraction_reduce_top_test.sv @@
// Testbench for the signed fraction reducer: checks each reduced fraction against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module gcd_fraction_reduce_top_test;
	localparam int W = 32;
	localparam int IN_W = ((2*W+7)/8)*8;
	localparam int OUT_W = ((3*W+7)/8)*8;
	localparam int IDLE_LIMIT = 50000;

	typedef struct packed {
		logic [W-1:0] rnum;
		logic [W-1:0] rden;
		logic [W-1:0] gcd;
		logic         zero_err;
	} fraction_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic m_axis_tuser;

	fraction_t reduced_q[$];
	int mismatches;
	int idle_cycles;
	bit timed_out;
	bit quiet;        // no random idling while set
	bit hold_output;  // receiver holds off while set

	gcd_fraction_reduce_top #(.DATA_WIDTH(W)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [W-1:0] mag(logic [W-1:0] x);
		return x[W-1] ? -x : x;
	endfunction

	function automatic logic [W-1:0] trunc_rem(logic [W-1:0] p, logic [W-1:0] q);
		logic [W-1:0] m;
		m = mag(p) % mag(q);
		return p[W-1] ? -m : m;
	endfunction

	function automatic logic [W-1:0] trunc_quo(logic [W-1:0] p, logic [W-1:0] q);
		logic [W-1:0] m;
		m = mag(p) / mag(q);
		return (p[W-1] != q[W-1]) ? -m : m;
	endfunction

	function automatic fraction_t reduce_fraction(logic [W-1:0] num, logic [W-1:0] den);
		logic [W-1:0] a, b, r;
		fraction_t f;
		a = num;
		b = den;
		while (b != '0) begin
			r = trunc_rem(a, b);
			a = b;
			b = r;
		end
		if (a == '0) begin
			f = '{rnum: '0, rden: '0, gcd: '0, zero_err: 1'b1};
		end else begin
			f = '{rnum: trunc_quo(num, a), rden: trunc_quo(den, a), gcd: a, zero_err: 1'b0};
		end
		return f;
	endfunction

	// The valid line stays high from one transfer to the next unless the sender idles.
	task automatic send_fraction(logic [W-1:0] num, logic [W-1:0] den);
		while (!quiet && $urandom_range(99) < 18) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {den, num};
		do @(posedge clk); while (!s_axis_tready);
		reduced_q.push_back(reduce_fraction(num, den));
	endtask

	function automatic logic [W-1:0] rand_value();
		case ($urandom_range(5))
			0: return $urandom_range(20);
			1: return -$urandom_range(20);
			2: return $urandom_range(1000) * (1 << $urandom_range(12));
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		logic [W-1:0] mn, mx;
		mn = {1'b1, {(W-1){1'b0}}};
		mx = {1'b0, {(W-1){1'b1}}};
		send_fraction(0, 0);
		send_fraction(12, 0);
		send_fraction(-12, 0);
		send_fraction(0, 7);
		send_fraction(0, -7);
		send_fraction(12, 18);
		send_fraction(-12, 18);
		send_fraction(12, -18);
		send_fraction(-12, -18);
		send_fraction(mn, -1);
		send_fraction(mn, 1);
		send_fraction(mn, mn);
		send_fraction(mn, 0);
		send_fraction(mx, mn);
		send_fraction(mx, mx);
		send_fraction(mx, 1);
		send_fraction(-1, -1);
		send_fraction('1, 32'h5555_5555);
		send_fraction(32'hAAAA_AAAA, 32'h5555_5555);
		send_fraction(1836311903, 1134903170); // Fibonacci pair, longest chain
		send_fraction(-1836311903, 1134903170);
	endtask

	task automatic test_random(int count);
		logic [W-1:0] g;
		repeat (count) begin
			if ($urandom_range(2) == 0) begin
				// Common factor so the reduction does real work.
				g = $urandom_range(1, 5000);
				send_fraction(g * $urandom_range(60000) * ($urandom_range(1) ? -1 : 1),
					g * $urandom_range(60000) * ($urandom_range(1) ? -1 : 1));
			end else begin
				send_fraction(rand_value(), rand_value());
			end
		end
	endtask

	task automatic test_quiet(int count);
		quiet = 1'b1;
		test_random(count);
		quiet = 1'b0;
	endtask

	task automatic test_backpressure(int count);
		hold_output = 1'b1;
		fork
			begin
				repeat (8000) @(posedge clk);
				hold_output = 1'b0;
			end
			test_random(count);
		join
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		mismatches = 0;
		quiet = 1'b0;
		hold_output = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(150);
		test_quiet(60);
		test_backpressure(20);
		test_random(120);
		s_axis_tvalid <= 1'b0;
		while (reduced_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && !timed_out)
			$display("gcd_fraction_reduce_top_test: PASS");
		else
			$display("gcd_fraction_reduce_top_test: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n)
			m_axis_tready <= !hold_output && (quiet || $urandom_range(99) >= 18);
	end

	always @(posedge clk) begin
		fraction_t want, got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[W-1:0], m_axis_tdata[2*W-1:W], m_axis_tdata[3*W-1:2*W],
				m_axis_tuser};
			if (reduced_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
			end else begin
				want = reduced_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: num %h/%h den %h/%h gcd %h/%h err %b/%b (exp/act)",
							want.rnum, got.rnum, want.rden, got.rden,
							want.gcd, got.gcd, want.zero_err, got.zero_err);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			timed_out = 1'b1;
			$display("gcd_fraction_reduce_top_test: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial idle_cycles = 0;
	initial timed_out = 1'b0;
endmodule
`default_nettype wire
